@@ sv/abb_pkg.sv @@
package abb_pkg;

  // Configuration register map, indexed by paddr[2].
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned DIM_REG_W   = 13;
  localparam int unsigned OFFSET_W    = 12;
  localparam int unsigned SIZE_W      = 13;
  localparam int unsigned ALPHA_SHIFT = 24;
  localparam int unsigned PIXEL_W     = 32;

  // Output bus widths: all fields but the flag, padded to whole bytes.
  localparam int unsigned RESULT_W    = 2 * OFFSET_W + 2 * SIZE_W;
  localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef struct packed {
    logic                advance;  // stage 1 item moves into the edge tracker
    logic                opaque;   // its alpha byte is nonzero
    logic                last;     // it is the final pixel of the frame
  } abb_ctl_t;

  typedef struct packed {
    logic                all_clear;
    logic [SIZE_W-1:0]   crop_height;
    logic [SIZE_W-1:0]   crop_width;
    logic [OFFSET_W-1:0] offset_y;
    logic [OFFSET_W-1:0] offset_x;
  } abb_result_t;

endpackage

@@ sv/alpha_bounding_box.sv @@
// Finds the bounding box of the pixels with nonzero alpha in a raster-order
// ARGB frame and reports it as a crop offset and size, one result per frame.
// One pixel is taken every cycle unless intake stalls; the result for a frame
// passes through an input register and the result register once its last
// pixel is accepted. Pixel intake stalls only when the last pixel of a frame
// is held and the previous result has not been taken. The frame size comes
// from image_width and image_height; 0 acts as 1 and values above MAX_DIM
// act as MAX_DIM. A frame with no opaque pixel reports offset 0,0, size 1x1
// and all_clear set. Sizes may be changed between pixels and act at once.
module alpha_bounding_box #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel[31:0]

  output logic        m_tvalid,
  input  logic        m_tready,
  // offset_x[11:0], offset_y[23:12], crop_width[36:24], crop_height[49:37], zero pad
  output logic [55:0] m_tdata,
  output logic        m_tuser,   // all_clear

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [abb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import abb_pkg::*;

  localparam int unsigned CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [CW-1:0] DIM_LIMIT = CW'(MAX_DIM - 1);

  logic [DIM_REG_W-1:0] image_width;
  logic [DIM_REG_W-1:0] image_height;
  logic [CW-1:0]        last_col;
  logic [CW-1:0]        last_row;

  logic [CW-1:0]        column_count;
  logic [CW-1:0]        row_count;
  logic                 row_end;
  logic                 frame_end;

  logic                 s1_valid;
  logic                 s1_opaque;
  logic                 s1_last;
  logic [CW-1:0]        s1_x;
  logic [CW-1:0]        s1_y;
  logic                 s1_move;
  logic                 in_take;

  abb_ctl_t             ext_ctl;
  abb_result_t          ext_result;
  abb_result_t          out_result;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_REG_W'(1);
      image_height <= DIM_REG_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2:2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2:2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  // Last column and row index after clamping the programmed size.
  always_comb begin
    if (image_width == '0)
      last_col = '0;
    else if (32'(image_width) > 32'(MAX_DIM))
      last_col = DIM_LIMIT;
    else
      last_col = CW'(image_width - DIM_REG_W'(1));

    if (image_height == '0)
      last_row = '0;
    else if (32'(image_height) > 32'(MAX_DIM))
      last_row = DIM_LIMIT;
    else
      last_row = CW'(image_height - DIM_REG_W'(1));
  end

  // A stage 1 item that ends a frame may move on only when the result
  // register is free or being emptied.
  assign s1_move  = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign in_take  = s_tvalid && s_tready;

  assign row_end   = column_count >= last_col;
  assign frame_end = row_end && (row_count >= last_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_take) begin
      if (row_end) begin
        column_count <= '0;
        if (frame_end) row_count <= '0;
        else           row_count <= row_count + CW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opaque <= s_tdata[PIXEL_W-1:ALPHA_SHIFT] != '0;
      s1_last   <= frame_end;
      s1_x      <= column_count;
      s1_y      <= row_count;
    end
  end

  assign ext_ctl.advance = s1_move;
  assign ext_ctl.opaque  = s1_opaque;
  assign ext_ctl.last    = s1_last;

  abb_extent #(
    .CW(CW)
  ) u_extent (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ext_ctl),
    .x      (s1_x),
    .y      (s1_y),
    .result (ext_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_last) out_result <= ext_result;
  end

  assign m_tdata = OUT_TDATA_W'({out_result.crop_height, out_result.crop_width,
                                 out_result.offset_y, out_result.offset_x});
  assign m_tuser = out_result.all_clear;

endmodule

@@ sv/abb_extent.sv @@
module abb_extent #(
  parameter int unsigned CW = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  abb_pkg::abb_ctl_t    ctl,
  input  logic [CW-1:0]        x,
  input  logic [CW-1:0]        y,
  output abb_pkg::abb_result_t result
);
  import abb_pkg::*;

  logic [CW-1:0] left_edge;
  logic [CW-1:0] right_edge;
  logic [CW-1:0] top_edge;
  logic [CW-1:0] bottom_edge;
  logic          opaque_seen;

  logic [CW-1:0] left_edge_next;
  logic [CW-1:0] right_edge_next;
  logic [CW-1:0] top_edge_next;
  logic [CW-1:0] bottom_edge_next;
  logic          opaque_seen_next;

  logic [31:0]   left_ext;
  logic [31:0]   top_ext;
  logic [31:0]   span_x;
  logic [31:0]   span_y;

  always_comb begin
    left_edge_next   = left_edge;
    right_edge_next  = right_edge;
    top_edge_next    = top_edge;
    bottom_edge_next = bottom_edge;
    opaque_seen_next = opaque_seen;
    if (ctl.opaque) begin
      if (!opaque_seen) begin
        left_edge_next   = x;
        right_edge_next  = x;
        top_edge_next    = y;
        bottom_edge_next = y;
        opaque_seen_next = 1'b1;
      end else begin
        if (x < left_edge)   left_edge_next   = x;
        if (x > right_edge)  right_edge_next  = x;
        if (y < top_edge)    top_edge_next    = y;
        if (y > bottom_edge) bottom_edge_next = y;
      end
    end
  end

  // With nothing opaque the edges are all zero, so the spans come out as 1.
  always_comb begin
    left_ext = 32'(left_edge_next);
    top_ext  = 32'(top_edge_next);
    span_x   = 32'(right_edge_next) - left_ext + 32'd1;
    span_y   = 32'(bottom_edge_next) - top_ext + 32'd1;
    result.offset_x    = left_ext[OFFSET_W-1:0];
    result.offset_y    = top_ext[OFFSET_W-1:0];
    result.crop_width  = span_x[SIZE_W-1:0];
    result.crop_height = span_y[SIZE_W-1:0];
    result.all_clear   = !opaque_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge   <= '0;
      right_edge  <= '0;
      top_edge    <= '0;
      bottom_edge <= '0;
      opaque_seen <= 1'b0;
    end else if (ctl.advance) begin
      if (ctl.last) begin
        left_edge   <= '0;
        right_edge  <= '0;
        top_edge    <= '0;
        bottom_edge <= '0;
        opaque_seen <= 1'b0;
      end else begin
        left_edge   <= left_edge_next;
        right_edge  <= right_edge_next;
        top_edge    <= top_edge_next;
        bottom_edge <= bottom_edge_next;
        opaque_seen <= opaque_seen_next;
      end
    end
  end

endmodule
